// ===== rtl/sorted_priority_queue_macros.svh =====
// Assertion macros used by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Condition that must never be seen outside reset.
`define SPQ_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/spq_pkg.sv =====
// Types and constants for the sorted priority queue.
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int PRIO_W = 8;
	localparam int OCC_W  = 5;
	localparam int STAT_W = 2;

	// Request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [DATA_W-1:0] item_data;
		logic [PRIO_W-1:0] item_priority;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] out_data;
		logic [PRIO_W-1:0] out_priority;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

	// One stored queue entry
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t item;
	} cell_ctl_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: a row of cells kept in descending priority order.
//
// Each request (insert or remove) raised with start is taken on that clock
// edge and answered by a single done beat in the next cycle, carrying status,
// removed data and priority, and the occupancy after the request. busy never
// rises, so one request per cycle is sustained: every cell compares its
// stored priority with the incoming one in the same cycle and shifts by one
// place, and the count register decides which cells hold live entries.
// Ties leave in arrival order. There is no back pressure on results: the
// receiver must take each done beat in the cycle it is shown.
`include "sorted_priority_queue_macros.svh"
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	logic                accept;
	logic                full;
	logic                empty;
	logic                rem_empty;
	cell_ctl_t           ctl;
	logic [CAPACITY-1:0] keep;
	entry_t              cells [CAPACITY];
	logic                done_q;
	rsp_t                rsp_q;
	rsp_t                rsp_nxt;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	// Broadcast control
	assign ctl.ins       = accept && (req.req_type == REQ_INSERT) && !full;
	assign ctl.rem       = accept && (req.req_type == REQ_REMOVE) && !empty;
	assign ctl.item.data = req.item_data;
	assign ctl.item.prio = req.item_priority;

	// Remove request that finds the queue empty
	assign rem_empty = accept && (req.req_type == REQ_REMOVE) && empty;

	// Row of cells, head at index 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   prev_keep;
		entry_t prev_entry;
		entry_t next_entry;

		if (i == 0) begin : g_head
			assign prev_keep  = 1'b1;
			assign prev_entry = ctl.item;
		end else begin : g_body
			assign prev_keep  = keep[i-1];
			assign prev_entry = cells[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_entry = cells[i];
		end else begin : g_link
			assign next_entry = cells[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (CNT_W'(i) < count_q),
			.prev_keep  (prev_keep),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.keep       (keep[i]),
			.entry      (cells[i])
		);
	end

	// Occupancy update
	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// Result beat
	always_comb begin
		rsp_nxt.status       = ST_OK;
		rsp_nxt.out_data     = '0;
		rsp_nxt.out_priority = '0;
		rsp_nxt.occupancy    = OCC_W'(count_nxt);
		if (req.req_type == REQ_INSERT) begin
			if (full) begin
				rsp_nxt.status = ST_FULL;
			end
		end else if (empty) begin
			rsp_nxt.status = ST_EMPTY;
		end else begin
			rsp_nxt.out_data     = cells[0].data;
			rsp_nxt.out_priority = cells[0].prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Checks
	`SPQ_ASSERT_NEVER(a_count_range, count_q > CNT_W'(CAPACITY), "count above capacity")
	`SPQ_ASSERT(a_one_beat, accept |=> done, "request without result beat")
	`SPQ_ASSERT(a_empty_status, rem_empty |=> (rsp.status == ST_EMPTY && empty), "bad empty status")
	`SPQ_ASSERT(a_ins_count, ctl.ins |=> (count_q == $past(count_q) + CNT_W'(1)), "count not grown")
	`SPQ_ASSERT(a_head_order, ctl.rem |=> (empty || cells[0].prio <= rsp.out_priority), "order broken")

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
module spq_cell
	import spq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      valid,
	input  logic      prev_keep,
	input  entry_t    prev_entry,
	input  entry_t    next_entry,
	output logic      keep,
	output entry_t    entry
);

	entry_t entry_q;

	// Entry stays put on insert when it ranks equal or above the new one
	assign keep  = valid && (entry_q.prio >= ctl.item.prio);
	assign entry = entry_q;

	// Insert: hold, take the new item at the boundary, or shift right.
	// Remove: shift left.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!keep) begin
				if (prev_keep) begin
					entry_q <= ctl.item;
				end else begin
					entry_q <= prev_entry;
				end
			end
		end else if (ctl.rem) begin
			entry_q <= next_entry;
		end
	end

endmodule
